// ----- sv/u8d_pkg.sv -----
`timescale 1ns / 1ps

package u8d_pkg;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NONE     = 3'd1,
    ST_BAD_LEAD = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_BAD_CONT = 3'd4,
    ST_OVERLONG = 3'd5,
    ST_INVALID  = 3'd6
  } status_t;

  // Lead byte class boundaries.
  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] LEAD2_MIN  = 8'hC2;
  localparam logic [7:0] LEAD2_MAX  = 8'hDF;
  localparam logic [7:0] LEAD3_MIN  = 8'hE0;
  localparam logic [7:0] LEAD3_MAX  = 8'hEF;
  localparam logic [7:0] LEAD4_MIN  = 8'hF0;
  localparam logic [7:0] LEAD4_MAX  = 8'hF4;

  // Code point limits.
  localparam logic [20:0] CP_MIN2      = 21'h000080;
  localparam logic [20:0] CP_MIN3      = 21'h000800;
  localparam logic [20:0] CP_MIN4      = 21'h010000;
  localparam logic [20:0] CP_MAX       = 21'h10FFFF;
  localparam logic [20:0] SURR_MIN     = 21'h00D800;
  localparam logic [20:0] SURR_MAX     = 21'h00DFFF;
  localparam logic [20:0] NONCHAR_FFFE = 21'h00FFFE;
  localparam logic [20:0] NONCHAR_FFFF = 21'h00FFFF;

  localparam logic [2:0] AVAIL_MAX = 3'd4;
  localparam int unsigned NUM_LANES = 3;

  // Input transaction.
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [2:0] available;
  } win_t;

  // Result transaction.
  typedef struct packed {
    status_t     status;
    logic [2:0]  seq_length;
    logic [20:0] code_point;
    logic [1:0]  bad_offset;
  } res_t;

  // Lead byte classification: length 0 means a bad lead.
  typedef struct packed {
    logic [2:0] len;
    logic [6:0] bits;
  } lead_t;

  // What one continuation lane reports.
  typedef struct packed {
    logic       cont_ok;
    logic [5:0] bits;
  } lane_t;

  // Registered lane findings handed to the merge stage.
  typedef struct packed {
    logic [2:0]                 avail;
    lead_t                      lead;
    lane_t [NUM_LANES-1:0]      lanes;
  } found_t;

endpackage

// ----- sv/u8d_lead.sv -----
`timescale 1ns / 1ps

module u8d_lead
  import u8d_pkg::*;
(
  input  logic [7:0] byte0,
  output lead_t      lead
);

  // Classify the lead byte and keep its payload bits.
  always_comb begin
    lead = '0;
    case (byte0) inside
      [8'h00:ASCII_MAX]: begin
        lead.len  = 3'd1;
        lead.bits = byte0[6:0];
      end
      [LEAD2_MIN:LEAD2_MAX]: begin
        lead.len  = 3'd2;
        lead.bits = {2'b00, byte0[4:0]};
      end
      [LEAD3_MIN:LEAD3_MAX]: begin
        lead.len  = 3'd3;
        lead.bits = {3'b000, byte0[3:0]};
      end
      [LEAD4_MIN:LEAD4_MAX]: begin
        lead.len  = 3'd4;
        lead.bits = {4'b0000, byte0[2:0]};
      end
      default: begin
        lead = '0;
      end
    endcase
  end

endmodule

// ----- sv/u8d_lane.sv -----
`timescale 1ns / 1ps

module u8d_lane
  import u8d_pkg::*;
(
  input  logic [7:0] data,
  output lane_t      lane
);

  // A continuation byte has the form 10xxxxxx.
  assign lane.cont_ok = (data[7:6] == 2'b10);
  assign lane.bits    = data[5:0];

endmodule

// ----- sv/u8d_merge.sv -----
`timescale 1ns / 1ps

module u8d_merge
  import u8d_pkg::*;
(
  input  found_t found,
  output res_t   res
);

  logic [2:0]  len;
  logic [2:0]  fail;
  logic [20:0] cp;
  logic        overlong;
  logic        invalid;

  assign len = found.lead.len;

  // A lane only counts when the sequence reaches its offset.
  assign fail[0] = (len >= 3'd2) && !found.lanes[0].cont_ok;
  assign fail[1] = (len >= 3'd3) && !found.lanes[1].cont_ok;
  assign fail[2] = (len == 3'd4) && !found.lanes[2].cont_ok;

  // Assemble the code point from the lead and lane payloads.
  always_comb begin
    case (len)
      3'd1:    cp = {14'd0, found.lead.bits};
      3'd2:    cp = {10'd0, found.lead.bits[4:0], found.lanes[0].bits};
      3'd3:    cp = {5'd0, found.lead.bits[3:0], found.lanes[0].bits,
                     found.lanes[1].bits};
      3'd4:    cp = {found.lead.bits[2:0], found.lanes[0].bits,
                     found.lanes[1].bits, found.lanes[2].bits};
      default: cp = '0;
    endcase
  end

  // Range checks per sequence length.
  always_comb begin
    case (len)
      3'd2:    overlong = (cp < CP_MIN2);
      3'd3:    overlong = (cp < CP_MIN3);
      3'd4:    overlong = (cp < CP_MIN4) || (cp > CP_MAX);
      default: overlong = 1'b0;
    endcase
  end

  assign invalid = ((cp >= SURR_MIN) && (cp <= SURR_MAX)) ||
                   (cp == NONCHAR_FFFE) || (cp == NONCHAR_FFFF);

  // Apply the checks in priority order.
  always_comb begin
    res = '0;
    if (found.avail == 3'd0) begin
      res.status = ST_NONE;
    end else if (len == 3'd0) begin
      res.status = ST_BAD_LEAD;
    end else if (found.avail < len) begin
      res.status = ST_TRUNC;
    end else if (fail[0]) begin
      res.status     = ST_BAD_CONT;
      res.bad_offset = 2'd1;
    end else if (fail[1]) begin
      res.status     = ST_BAD_CONT;
      res.bad_offset = 2'd2;
    end else if (fail[2]) begin
      res.status     = ST_BAD_CONT;
      res.bad_offset = 2'd3;
    end else if (overlong) begin
      res.status = ST_OVERLONG;
    end else if (invalid) begin
      res.status = ST_INVALID;
    end else begin
      res.status     = ST_OK;
      res.seq_length = len;
      res.code_point = cp;
    end
  end

endmodule

// ----- sv/utf8_sequence_decoder.sv -----
`timescale 1ns / 1ps

// UTF-8 sequence decoder.
// The win channel carries a four-byte window of text and the count of bytes
// still available (values above four mean four or more). For each window the
// res channel returns one transaction: a status, the sequence length, the
// decoded code point and, for a bad continuation byte, its offset.
// Both channels use valid/ready; a transaction moves when both are high.
// From acceptance to res_valid a window passes the lane register, holding
// what the lead classifier and the three continuation lanes found, and then
// the output register, holding the merged result. One transaction is taken
// every cycle as long as the receiver takes results.
// When res_ready is low the result holds and the lane register can still
// take one more window; after that win_ready drops until the output drains.
// Synchronous reset empties both registers; no result is pending afterward.
module utf8_sequence_decoder
  import u8d_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic win_valid,
  output logic win_ready,
  input  win_t win,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  lead_t                 lead;
  lane_t [NUM_LANES-1:0] lanes;
  found_t                found_next;
  found_t                found;
  logic                  found_valid;
  res_t                  merged;
  logic                  out_advance;
  logic                  win_take;

  // Lead classifier and one lane per continuation offset.
  u8d_lead u_lead (
    .byte0 (win.byte0),
    .lead  (lead)
  );

  u8d_lane u_lane1 (.data(win.byte1), .lane(lanes[0]));
  u8d_lane u_lane2 (.data(win.byte2), .lane(lanes[1]));
  u8d_lane u_lane3 (.data(win.byte3), .lane(lanes[2]));

  always_comb begin
    found_next.avail = (win.available > AVAIL_MAX) ? AVAIL_MAX : win.available;
    found_next.lead  = lead;
    found_next.lanes = lanes;
  end

  // Pipeline flow control.
  assign out_advance = !res_valid || res_ready;
  assign win_ready   = !found_valid || out_advance;
  assign win_take    = win_valid && win_ready;

  // Lane findings register.
  always_ff @(posedge clk) begin
    if (rst) begin
      found_valid <= 1'b0;
    end else if (win_ready) begin
      found_valid <= win_valid;
    end
    if (win_take) begin
      found <= found_next;
    end
  end

  u8d_merge u_merge (
    .found (found),
    .res   (merged)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_advance) begin
      res_valid <= found_valid;
    end
    if (out_advance && found_valid) begin
      res <= merged;
    end
  end

endmodule

// ----- sv/u8d_checker.sv -----
`timescale 1ns / 1ps

module u8d_checker
  import u8d_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic win_valid,
  input logic win_ready,
  input win_t win,
  input logic res_valid,
  input logic res_ready,
  input res_t res
);

  // A stalled result stays put.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  // An accepted window is followed by a valid result at the output.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    win_valid && win_ready |=> ##1 res_valid)
    else $error("accepted window produced no result");

  // Errors carry no length or code point, and only a bad continuation
  // carries an offset.
  a_error_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res.status == ST_OK) ||
                   (res.seq_length == 3'd0 && res.code_point == 21'd0)) &&
                  ((res.status == ST_BAD_CONT) || (res.bad_offset == 2'd0)))
    else $error("inconsistent result fields");

endmodule

bind utf8_sequence_decoder u8d_checker u_checker (.*);

// ----- tb/tb_utf8_sequence_decoder.sv -----
`timescale 1ns / 1ps

module tb_utf8_sequence_decoder;
  import u8d_pkg::*;

  localparam int unsigned RANDOM_WINDOWS = 1300;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned HOLD_AFTER     = 400;
  localparam int unsigned HOLD_CYCLES    = 300;

  // Receiver behavior outside the long hold-off.
  typedef enum logic [1:0] {
    RX_STREAM,
    RX_RANDOM,
    RX_SLOW
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic win_valid = 1'b0;
  logic win_ready;
  win_t win = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  win_t window_q[$];
  res_t decoded_q[$];

  logic win_fire = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  logic hold_done = 1'b0;
  int unsigned mode_left = 0;
  rx_mode_t rx_mode = RX_STREAM;

  utf8_sequence_decoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .win       (win),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always #6 clk = ~clk;

  // Decode one window the way the block is specified to.
  function automatic res_t decode_window(win_t w);
    res_t r;
    logic [7:0] b [4];
    logic [2:0] avail;
    int unsigned len;
    logic [20:0] cp;
    int k;
    b[0] = w.byte0;
    b[1] = w.byte1;
    b[2] = w.byte2;
    b[3] = w.byte3;
    r.status = ST_OK;
    r.seq_length = '0;
    r.code_point = '0;
    r.bad_offset = '0;
    cp = '0;
    len = 0;
    avail = (w.available > AVAIL_MAX) ? AVAIL_MAX : w.available;
    if (avail == 3'd0) begin
      r.status = ST_NONE;
    end else begin
      if (b[0] <= ASCII_MAX) len = 1;
      else if (b[0] >= LEAD2_MIN && b[0] <= LEAD2_MAX) len = 2;
      else if (b[0] >= LEAD3_MIN && b[0] <= LEAD3_MAX) len = 3;
      else if (b[0] >= LEAD4_MIN && b[0] <= LEAD4_MAX) len = 4;
      if (len == 0) begin
        r.status = ST_BAD_LEAD;
      end else if (avail < len) begin
        r.status = ST_TRUNC;
      end else begin
        // The first byte outside 80..BF is the one reported.
        for (k = 1; k < len; k++) begin
          if (r.status == ST_OK && b[k][7:6] != 2'b10) begin
            r.status = ST_BAD_CONT;
            r.bad_offset = k[1:0];
          end
        end
        if (r.status == ST_OK) begin
          case (len)
            1: cp = {14'd0, b[0][6:0]};
            2: cp = {10'd0, b[0][4:0], b[1][5:0]};
            3: cp = {5'd0, b[0][3:0], b[1][5:0], b[2][5:0]};
            default: cp = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
          endcase
          if ((len == 2 && cp < CP_MIN2) || (len == 3 && cp < CP_MIN3) ||
              (len == 4 && (cp < CP_MIN4 || cp > CP_MAX))) begin
            r.status = ST_OVERLONG;
          end else if ((cp >= SURR_MIN && cp <= SURR_MAX) ||
                       cp == NONCHAR_FFFE || cp == NONCHAR_FFFF) begin
            r.status = ST_INVALID;
          end
        end
      end
    end
    if (r.status == ST_OK) begin
      r.seq_length = len[2:0];
      r.code_point = cp;
    end
    return r;
  endfunction

  // Encode a code point in the given length, whether or not that is legal;
  // bytes past the sequence carry random filler.
  function automatic win_t encode_window(logic [20:0] cp, int unsigned len, logic [2:0] avail);
    win_t w;
    w.byte0 = 8'($urandom_range(0, 255));
    w.byte1 = 8'($urandom_range(0, 255));
    w.byte2 = 8'($urandom_range(0, 255));
    w.byte3 = 8'($urandom_range(0, 255));
    w.available = avail;
    case (len)
      1: w.byte0 = {1'b0, cp[6:0]};
      2: begin
        w.byte0 = {3'b110, cp[10:6]};
        w.byte1 = {2'b10, cp[5:0]};
      end
      3: begin
        w.byte0 = {4'b1110, cp[15:12]};
        w.byte1 = {2'b10, cp[11:6]};
        w.byte2 = {2'b10, cp[5:0]};
      end
      default: begin
        w.byte0 = {5'b11110, cp[20:18]};
        w.byte1 = {2'b10, cp[17:12]};
        w.byte2 = {2'b10, cp[11:6]};
        w.byte3 = {2'b10, cp[5:0]};
      end
    endcase
    return w;
  endfunction

  task automatic queue_window(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, logic [7:0] b3,
                              logic [2:0] avail);
    win_t w;
    w.byte0 = b0;
    w.byte1 = b1;
    w.byte2 = b2;
    w.byte3 = b3;
    w.available = avail;
    window_q.push_back(w);
  endtask

  // Stimulus, reset and the end of the run.
  initial begin : stimulus
    int unsigned i;
    int unsigned kind;
    int unsigned len;
    int unsigned k;
    logic [20:0] cp;
    logic [7:0] junk;
    win_t w;

    // Directed windows: empty buffer, saturated count, each lead class and error.
    queue_window(8'($urandom_range(0, 255)), 8'h80, 8'h80, 8'h80, 3'd0);
    queue_window(8'h00, 8'hFF, 8'hFF, 8'hFF, 3'd1);
    queue_window(8'h7F, 8'h00, 8'h00, 8'h00, 3'd7);
    queue_window(8'h80, 8'h80, 8'h80, 8'h80, 3'd4);
    queue_window(8'hC1, 8'hBF, 8'h00, 8'h00, 3'd5);
    queue_window(8'hF5, 8'h80, 8'h80, 8'h80, 3'd6);
    queue_window(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd4);
    queue_window(8'hC2, 8'h80, 8'h00, 8'h00, 3'd2);
    queue_window(8'hDF, 8'hBF, 8'hFF, 8'hFF, 3'd7);
    queue_window(8'hC2, 8'h80, 8'h00, 8'h00, 3'd1);
    queue_window(8'hE0, 8'hA0, 8'h80, 8'h00, 3'd2);
    queue_window(8'hF0, 8'h90, 8'h80, 8'h80, 3'd3);
    queue_window(8'hC2, 8'h41, 8'h00, 8'h00, 3'd4);
    queue_window(8'hE1, 8'h80, 8'hC0, 8'h00, 3'd4);
    queue_window(8'hF1, 8'h80, 8'h80, 8'h7F, 3'd4);
    queue_window(8'hE0, 8'h9F, 8'hBF, 8'h00, 3'd3);
    queue_window(8'hF0, 8'h8F, 8'hBF, 8'hBF, 3'd4);
    queue_window(8'hF4, 8'h90, 8'h80, 8'h80, 3'd4);
    queue_window(8'hED, 8'hA0, 8'h80, 8'h00, 3'd3);
    queue_window(8'hED, 8'hBF, 8'hBF, 8'h00, 3'd3);
    queue_window(8'hEF, 8'hBF, 8'hBE, 8'h00, 3'd3);
    queue_window(8'hEF, 8'hBF, 8'hBF, 8'h00, 3'd4);
    queue_window(8'hED, 8'h9F, 8'hBF, 8'h00, 3'd3);
    queue_window(8'hE0, 8'hA0, 8'h80, 8'h00, 3'd3);
    queue_window(8'hF4, 8'h8F, 8'hBF, 8'hBF, 3'd4);
    queue_window(8'hF0, 8'h90, 8'h80, 8'h80, 3'd7);

    // Random windows, mostly well-formed text with a share of each error.
    for (i = 0; i < RANDOM_WINDOWS; i++) begin
      kind = $urandom_range(0, 99);
      len = $urandom_range(1, 4);
      case (len)
        1: cp = 21'($urandom_range(0, 'h7F));
        2: cp = 21'($urandom_range('h80, 'h7FF));
        3: cp = 21'($urandom_range('h800, 'hFFFF));
        default: cp = 21'($urandom_range('h10000, 'h10FFFF));
      endcase
      if (kind < 55) begin
        w = encode_window(cp, len, 3'($urandom_range(len, 7)));
      end else if (kind < 62) begin
        // Around the surrogate block and the top of the basic plane.
        cp = ($urandom_range(0, 1) == 0) ? 21'($urandom_range('hD7F0, 'hE00F))
                                         : 21'($urandom_range('hFFF0, 'hFFFF));
        w = encode_window(cp, 3, 3'($urandom_range(3, 7)));
      end else if (kind < 68) begin
        // Overlong: a value that fits in a shorter form.
        len = $urandom_range(2, 4);
        case (len)
          2: cp = 21'($urandom_range(0, 'h7F));
          3: cp = 21'($urandom_range(0, 'h7FF));
          default: cp = 21'($urandom_range(0, 'hFFFF));
        endcase
        w = encode_window(cp, len, 3'($urandom_range(len, 7)));
      end else if (kind < 72) begin
        // Beyond the last plane.
        w = encode_window(21'($urandom_range('h110000, 'h1FFFFF)), 4,
                          3'($urandom_range(4, 7)));
      end else if (kind < 80) begin
        len = $urandom_range(2, 4);
        w = encode_window(cp, len, 3'($urandom_range(1, len - 1)));
      end else if (kind < 88) begin
        len = $urandom_range(2, 4);
        case (len)
          2: cp = 21'($urandom_range('h80, 'h7FF));
          3: cp = 21'($urandom_range('h800, 'hFFFF));
          default: cp = 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        w = encode_window(cp, len, 3'($urandom_range(len, 7)));
        k = $urandom_range(1, len - 1);
        junk = 8'($urandom_range(0, 255));
        if (junk[7:6] == 2'b10) junk[6] = 1'b1;
        case (k)
          1: w.byte1 = junk;
          2: w.byte2 = junk;
          default: w.byte3 = junk;
        endcase
      end else begin
        w.byte0 = 8'($urandom_range(0, 255));
        w.byte1 = 8'($urandom_range(0, 255));
        w.byte2 = 8'($urandom_range(0, 255));
        w.byte3 = 8'($urandom_range(0, 255));
        w.available = 3'($urandom_range(0, 7));
      end
      window_q.push_back(w);
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (window_q.size() != 0 || win_valid || decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_utf8_sequence_decoder passed");
    end else begin
      $display("tb_utf8_sequence_decoder failed");
    end
    $finish;
  end

  // Window driver: bursts of random length separated by random gaps.
  always @(negedge clk) begin : drive_win
    logic nxt_valid;
    win_t nxt_win;
    nxt_valid = win_valid;
    nxt_win = win;
    if (!rst && (!win_valid || win_fire)) begin
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (window_q.size() > 0) begin
        nxt_win = window_q.pop_front();
        nxt_valid = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    win_valid <= nxt_valid;
    win <= nxt_win;
  end

  // Result receiver: changing stall patterns and one long hold-off.
  always @(negedge clk) begin : drive_res_ready
    logic nxt_ready;
    if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      mode_left = $urandom_range(20, 150);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      nxt_ready = 1'b0;
    end else begin
      case (rx_mode)
        RX_STREAM: nxt_ready = 1'b1;
        RX_RANDOM: nxt_ready = 1'($urandom_range(0, 1));
        default:   nxt_ready = ($urandom_range(0, 3) == 0);
      endcase
    end
    res_ready <= nxt_ready;
  end

  // Record accepted windows and check each accepted result against the oldest prediction.
  always @(posedge clk) begin : monitor
    res_t want;
    win_fire = win_valid && win_ready;
    if (!rst && win_fire) decoded_q.push_back(decode_window(win));
    if (!rst && res_valid && res_ready) begin
      results_seen++;
      if (decoded_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result transaction with nothing expected: status %0d len %0d cp %h",
                   $realtime, res.status, res.seq_length, res.code_point);
      end else begin
        want = decoded_q.pop_front();
        if (res.status !== want.status || res.seq_length !== want.seq_length ||
            res.code_point !== want.code_point || res.bad_offset !== want.bad_offset) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"%0t: mismatch: expected status %0d len %0d cp %h off %0d, ",
                      "got status %0d len %0d cp %h off %0d"},
                     $realtime, want.status, want.seq_length, want.code_point, want.bad_offset,
                     res.status, res.seq_length, res.code_point, res.bad_offset);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_utf8_sequence_decoder failed");
      $finish;
    end
  end

endmodule
